@@ rtl/fflsh_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fflsh_pkg;

  localparam int VERT_W  = 16;
  localparam int EDGE_W  = 17;
  localparam int PROD_W  = 34;
  localparam int NORM_W  = 35;
  localparam int NMAG_W  = 34;
  localparam int MMAG_W  = 30;
  localparam int MSG_W   = 31;
  localparam int SQP_W   = 60;
  localparam int DOTP_W  = 47;
  localparam int SQ_W    = 62;
  localparam int DOT_W   = 48;
  localparam int ROOT_W  = 31;
  localparam int SREM_W  = 33;
  localparam int DREM_W  = 47;
  localparam int DIFF_W  = 16;
  localparam int WGT_W   = 15;
  localparam int DPROD_W = 31;
  localparam int LIGHT_W = 18;
  localparam int CPROD_W = 26;
  localparam int FRAC_W  = 14;
  localparam int CH_W    = 8;

  localparam logic [2:0] REG_SUN_X   = 3'd0;
  localparam logic [2:0] REG_SUN_Y   = 3'd1;
  localparam logic [2:0] REG_SUN_Z   = 3'd2;
  localparam logic [2:0] REG_AMBIENT = 3'd3;
  localparam logic [2:0] REG_DIFFUSE = 3'd4;

  localparam logic signed [VERT_W-1:0] SUN_X_RST   = 16'sd9339;
  localparam logic signed [VERT_W-1:0] SUN_Y_RST   = 16'sd12124;
  localparam logic signed [VERT_W-1:0] SUN_Z_RST   = 16'sd5898;
  localparam logic [WGT_W-1:0]         AMBIENT_RST = 15'd6226;
  localparam logic [WGT_W-1:0]         DIFFUSE_RST = 15'd10158;

  typedef struct packed {
    logic [CH_W-1:0]          base_red;
    logic [CH_W-1:0]          base_green;
    logic [CH_W-1:0]          base_blue;
    logic signed [VERT_W-1:0] vert0_x;
    logic signed [VERT_W-1:0] vert0_y;
    logic signed [VERT_W-1:0] vert0_z;
    logic signed [VERT_W-1:0] vert1_x;
    logic signed [VERT_W-1:0] vert1_y;
    logic signed [VERT_W-1:0] vert1_z;
    logic signed [VERT_W-1:0] vert2_x;
    logic signed [VERT_W-1:0] vert2_y;
    logic signed [VERT_W-1:0] vert2_z;
  } in_beat_t;

  typedef struct packed {
    logic [CH_W-1:0] lit_red;
    logic [CH_W-1:0] lit_green;
    logic [CH_W-1:0] lit_blue;
  } out_beat_t;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } rgb_t;

  typedef struct packed {
    logic signed [VERT_W-1:0] sun_x;
    logic signed [VERT_W-1:0] sun_y;
    logic signed [VERT_W-1:0] sun_z;
    logic [WGT_W-1:0]         ambient_weight;
    logic [WGT_W-1:0]         diffuse_weight;
  } shade_cfg_t;

  typedef struct packed {
    logic [SREM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
  } sqrt_acc_t;

  typedef struct packed {
    logic [DREM_W-1:0] rem;
    logic [DIFF_W-1:0] q;
  } div_acc_t;

  // one root digit: bring down two radicand bits, try (root<<2)|1
  function automatic sqrt_acc_t sqrt_step(sqrt_acc_t a, logic [1:0] pair);
    logic [SREM_W+1:0] cur;
    logic [SREM_W+1:0] trial;
    sqrt_acc_t         o;
    cur   = {a.rem, pair};
    trial = {2'b00, a.root, 2'b01};
    if (cur >= trial) begin
      o.rem  = SREM_W'(cur - trial);
      o.root = {a.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = cur[SREM_W-1:0];
      o.root = {a.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // one restoring quotient bit at weight 2^sh
  function automatic div_acc_t div_step(div_acc_t a, logic [ROOT_W-1:0] len, int sh);
    logic [DREM_W-1:0] dvs;
    div_acc_t          o;
    dvs = DREM_W'(len) << sh;
    o   = a;
    if (a.rem >= dvs) begin
      o.rem = a.rem - dvs;
      o.q   = {a.q[DIFF_W-2:0], 1'b1};
    end else begin
      o.q   = {a.q[DIFF_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

`default_nettype wire

@@ rtl/fflsh_geom.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fflsh_geom (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fflsh_pkg::shade_cfg_t               cfg,
  input  logic                                up_vld,
  output logic                                up_rdy,
  input  fflsh_pkg::in_beat_t                 up_data,
  output logic                                dn_vld,
  input  logic                                dn_rdy,
  output logic [fflsh_pkg::SQ_W-1:0]          dn_sq,
  output logic signed [fflsh_pkg::DOT_W-1:0]  dn_dot,
  output fflsh_pkg::rgb_t                     dn_rgb
);
  import fflsh_pkg::*;

  localparam int NST = 7;

  logic [NST-1:0] v_r;
  logic [NST-1:0] en;
  rgb_t           rgb_r [NST];

  logic signed [EDGE_W-1:0] e1_r [3];
  logic signed [EDGE_W-1:0] e2_r [3];
  logic signed [PROD_W-1:0] p_r  [6];
  logic signed [NORM_W-1:0] n_r  [3];
  logic [NMAG_W-1:0]        nmag_r [3];
  logic                     nneg_r [3];
  logic [MMAG_W-1:0]        mmag_r [3];
  logic signed [MSG_W-1:0]  m_r  [3];
  logic [SQP_W-1:0]         sqp_r [3];
  logic signed [DOTP_W-1:0] dp_r [3];
  logic [SQ_W-1:0]          sq_r;
  logic signed [DOT_W-1:0]  dot_r;

  logic [NMAG_W-1:0]        mx;
  logic [2:0]               k;
  logic [MMAG_W-1:0]        mmag_nxt [3];
  logic signed [MSG_W-1:0]  m_nxt [3];

  assign en[NST-1] = !v_r[NST-1] || dn_rdy;
  for (genvar i = 0; i < NST-1; i++) begin : g_en
    assign en[i] = !v_r[i] || en[i+1];
  end

  assign up_rdy = en[0];
  assign dn_vld = v_r[NST-1];
  assign dn_sq  = sq_r;
  assign dn_dot = dot_r;
  assign dn_rgb = rgb_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_vld;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) rgb_r[0] <= '{r: up_data.base_red, g: up_data.base_green,
                             b: up_data.base_blue};
    for (int i = 1; i < NST; i++) begin
      if (en[i]) rgb_r[i] <= rgb_r[i-1];
    end
  end

  // narrowing shift: smallest k with max|n| >> k below 2^30
  always_comb begin
    mx = nmag_r[0];
    if (nmag_r[1] > mx) mx = nmag_r[1];
    if (nmag_r[2] > mx) mx = nmag_r[2];
    priority if (mx[33]) k = 3'd4;
    else if (mx[32])     k = 3'd3;
    else if (mx[31])     k = 3'd2;
    else if (mx[30])     k = 3'd1;
    else                 k = 3'd0;
    for (int i = 0; i < 3; i++) begin
      mmag_nxt[i] = MMAG_W'(nmag_r[i] >> k);
      m_nxt[i]    = nneg_r[i] ? -$signed({1'b0, mmag_nxt[i]}) : $signed({1'b0, mmag_nxt[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      e1_r[0] <= EDGE_W'(up_data.vert1_x) - EDGE_W'(up_data.vert0_x);
      e1_r[1] <= EDGE_W'(up_data.vert1_y) - EDGE_W'(up_data.vert0_y);
      e1_r[2] <= EDGE_W'(up_data.vert1_z) - EDGE_W'(up_data.vert0_z);
      e2_r[0] <= EDGE_W'(up_data.vert2_x) - EDGE_W'(up_data.vert0_x);
      e2_r[1] <= EDGE_W'(up_data.vert2_y) - EDGE_W'(up_data.vert0_y);
      e2_r[2] <= EDGE_W'(up_data.vert2_z) - EDGE_W'(up_data.vert0_z);
    end
    if (en[1]) begin
      p_r[0] <= PROD_W'(e1_r[1]) * PROD_W'(e2_r[2]);
      p_r[1] <= PROD_W'(e1_r[2]) * PROD_W'(e2_r[1]);
      p_r[2] <= PROD_W'(e1_r[2]) * PROD_W'(e2_r[0]);
      p_r[3] <= PROD_W'(e1_r[0]) * PROD_W'(e2_r[2]);
      p_r[4] <= PROD_W'(e1_r[0]) * PROD_W'(e2_r[1]);
      p_r[5] <= PROD_W'(e1_r[1]) * PROD_W'(e2_r[0]);
    end
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        n_r[i] <= NORM_W'(p_r[2*i]) - NORM_W'(p_r[2*i+1]);
      end
    end
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        nneg_r[i] <= n_r[i][NORM_W-1];
        nmag_r[i] <= n_r[i][NORM_W-1] ? NMAG_W'(-n_r[i]) : NMAG_W'(n_r[i]);
      end
    end
    if (en[4]) begin
      for (int i = 0; i < 3; i++) begin
        mmag_r[i] <= mmag_nxt[i];
        m_r[i]    <= m_nxt[i];
      end
    end
    if (en[5]) begin
      for (int i = 0; i < 3; i++) begin
        sqp_r[i] <= SQP_W'(mmag_r[i]) * SQP_W'(mmag_r[i]);
      end
      dp_r[0] <= DOTP_W'(cfg.sun_x) * DOTP_W'(m_r[0]);
      dp_r[1] <= DOTP_W'(cfg.sun_y) * DOTP_W'(m_r[1]);
      dp_r[2] <= DOTP_W'(cfg.sun_z) * DOTP_W'(m_r[2]);
    end
    if (en[6]) begin
      sq_r  <= SQ_W'(sqp_r[0]) + SQ_W'(sqp_r[1]) + SQ_W'(sqp_r[2]);
      dot_r <= DOT_W'(dp_r[0]) + DOT_W'(dp_r[1]) + DOT_W'(dp_r[2]);
    end
  end

endmodule

`default_nettype wire

@@ rtl/fflsh_sqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fflsh_sqrt (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                up_vld,
  output logic                                up_rdy,
  input  logic [fflsh_pkg::SQ_W-1:0]          up_sq,
  input  logic signed [fflsh_pkg::DOT_W-1:0]  up_dot,
  input  fflsh_pkg::rgb_t                     up_rgb,
  output logic                                dn_vld,
  input  logic                                dn_rdy,
  output logic [fflsh_pkg::ROOT_W-1:0]        dn_len,
  output logic signed [fflsh_pkg::DOT_W-1:0]  dn_dot,
  output fflsh_pkg::rgb_t                     dn_rgb
);
  import fflsh_pkg::*;

  // two root bits per stage, one in the last stage
  localparam int NST = (ROOT_W + 1) / 2;

  logic [NST-1:0]          v_r;
  logic [NST-1:0]          en;
  sqrt_acc_t               acc_q [NST];
  logic [SQ_W-1:0]         x_q   [NST];
  logic signed [DOT_W-1:0] dot_q [NST];
  rgb_t                    rgb_q [NST];

  assign en[NST-1] = !v_r[NST-1] || dn_rdy;
  for (genvar i = 0; i < NST-1; i++) begin : g_en
    assign en[i] = !v_r[i] || en[i+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_vld;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  for (genvar s = 0; s < NST; s++) begin : g_st
    sqrt_acc_t               acc_in, acc_mid, acc_nxt, acc_r;
    logic [SQ_W-1:0]         x_in, x_r;
    logic signed [DOT_W-1:0] dot_in, dot_r;
    rgb_t                    rgb_in, rgb_r;

    if (s == 0) begin : g_first
      assign acc_in = '0;
      assign x_in   = up_sq;
      assign dot_in = up_dot;
      assign rgb_in = up_rgb;
    end else begin : g_next
      assign acc_in = acc_q[s-1];
      assign x_in   = x_q[s-1];
      assign dot_in = dot_q[s-1];
      assign rgb_in = rgb_q[s-1];
    end

    assign acc_mid = sqrt_step(acc_in, x_in[SQ_W-1-4*s -: 2]);
    if (2*s + 1 < ROOT_W) begin : g_two
      assign acc_nxt = sqrt_step(acc_mid, x_in[SQ_W-3-4*s -: 2]);
    end else begin : g_one
      assign acc_nxt = acc_mid;
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        acc_r <= acc_nxt;
        x_r   <= x_in;
        dot_r <= dot_in;
        rgb_r <= rgb_in;
      end
    end

    assign acc_q[s] = acc_r;
    assign x_q[s]   = x_r;
    assign dot_q[s] = dot_r;
    assign rgb_q[s] = rgb_r;
  end

  assign up_rdy = en[0];
  assign dn_vld = v_r[NST-1];
  assign dn_len = acc_q[NST-1].root;
  assign dn_dot = dot_q[NST-1];
  assign dn_rgb = rgb_q[NST-1];

endmodule

`default_nettype wire

@@ rtl/fflsh_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fflsh_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                up_vld,
  output logic                                up_rdy,
  input  logic [fflsh_pkg::ROOT_W-1:0]        up_len,
  input  logic signed [fflsh_pkg::DOT_W-1:0]  up_dot,
  input  fflsh_pkg::rgb_t                     up_rgb,
  output logic                                dn_vld,
  input  logic                                dn_rdy,
  output logic [fflsh_pkg::DIFF_W-1:0]        dn_diff,
  output fflsh_pkg::rgb_t                     dn_rgb
);
  import fflsh_pkg::*;

  // one setup stage, then two quotient bits per stage
  localparam int NQ  = DIFF_W / 2;
  localparam int NST = NQ + 1;

  logic [NST-1:0]    v_r;
  logic [NST-1:0]    en;
  div_acc_t          acc_q  [NST];
  logic [ROOT_W-1:0] len_q  [NST];
  logic              zero_q [NST];
  logic              sat_q  [NST];
  rgb_t              rgb_q  [NST];

  div_acc_t          acc0_r;
  logic [ROOT_W-1:0] len0_r;
  logic              zero0_r, sat0_r;
  rgb_t              rgb0_r;

  assign en[NST-1] = !v_r[NST-1] || dn_rdy;
  for (genvar i = 0; i < NST-1; i++) begin : g_en
    assign en[i] = !v_r[i] || en[i+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_vld;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // face turned away, zero dot or degenerate normal give no diffuse light;
  // a quotient of 2^16 or more saturates
  always_ff @(posedge clk) begin
    if (en[0]) begin
      zero0_r    <= up_dot[DOT_W-1] || (up_dot == '0) || (up_len == '0);
      sat0_r     <= up_dot[DREM_W-1:0] >= {up_len, {DIFF_W{1'b0}}};
      acc0_r.rem <= up_dot[DREM_W-1:0];
      acc0_r.q   <= '0;
      len0_r     <= up_len;
      rgb0_r     <= up_rgb;
    end
  end

  assign acc_q[0]  = acc0_r;
  assign len_q[0]  = len0_r;
  assign zero_q[0] = zero0_r;
  assign sat_q[0]  = sat0_r;
  assign rgb_q[0]  = rgb0_r;

  for (genvar s = 1; s < NST; s++) begin : g_st
    div_acc_t          acc_mid, acc_nxt, acc_r;
    logic [ROOT_W-1:0] len_r;
    logic              zero_r, sat_r;
    rgb_t              rgb_r;

    assign acc_mid = div_step(acc_q[s-1], len_q[s-1], DIFF_W + 1 - 2*s);
    assign acc_nxt = div_step(acc_mid, len_q[s-1], DIFF_W - 2*s);

    always_ff @(posedge clk) begin
      if (en[s]) begin
        acc_r  <= acc_nxt;
        len_r  <= len_q[s-1];
        zero_r <= zero_q[s-1];
        sat_r  <= sat_q[s-1];
        rgb_r  <= rgb_q[s-1];
      end
    end

    assign acc_q[s]  = acc_r;
    assign len_q[s]  = len_r;
    assign zero_q[s] = zero_r;
    assign sat_q[s]  = sat_r;
    assign rgb_q[s]  = rgb_r;
  end

  assign up_rdy  = en[0];
  assign dn_vld  = v_r[NST-1];
  assign dn_diff = zero_q[NST-1] ? '0 : (sat_q[NST-1] ? '1 : acc_q[NST-1].q);
  assign dn_rgb  = rgb_q[NST-1];

endmodule

`default_nettype wire

@@ rtl/fflsh_shade.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fflsh_shade (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fflsh_pkg::shade_cfg_t         cfg,
  input  logic                          up_vld,
  output logic                          up_rdy,
  input  logic [fflsh_pkg::DIFF_W-1:0]  up_diff,
  input  fflsh_pkg::rgb_t               up_rgb,
  output logic                          dn_vld,
  input  logic                          dn_rdy,
  output fflsh_pkg::out_beat_t          dn_data
);
  import fflsh_pkg::*;

  localparam int NST = 4;

  logic [NST-1:0]     v_r;
  logic [NST-1:0]     en;
  rgb_t               rgb_r [NST-2];
  logic [DPROD_W-1:0] dprod_r;
  logic [LIGHT_W-1:0] light_r;
  logic [CPROD_W-1:0] cprod_r [3];
  logic [CH_W-1:0]    ch_r [3];
  logic [CH_W-1:0]    ch_nxt [3];
  logic [CPROD_W-FRAC_W-1:0] ch_full;

  assign en[NST-1] = !v_r[NST-1] || dn_rdy;
  for (genvar i = 0; i < NST-1; i++) begin : g_en
    assign en[i] = !v_r[i] || en[i+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_vld;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  always_comb begin
    ch_full = '0;
    for (int i = 0; i < 3; i++) begin
      ch_full   = cprod_r[i][CPROD_W-1:FRAC_W];
      ch_nxt[i] = (ch_full > (CPROD_W-FRAC_W)'({CH_W{1'b1}})) ? '1 : ch_full[CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dprod_r  <= DPROD_W'(cfg.diffuse_weight) * DPROD_W'(up_diff);
      rgb_r[0] <= up_rgb;
    end
    if (en[1]) begin
      light_r  <= LIGHT_W'(cfg.ambient_weight) + LIGHT_W'(dprod_r >> FRAC_W);
      rgb_r[1] <= rgb_r[0];
    end
    if (en[2]) begin
      cprod_r[0] <= CPROD_W'(rgb_r[1].r) * CPROD_W'(light_r);
      cprod_r[1] <= CPROD_W'(rgb_r[1].g) * CPROD_W'(light_r);
      cprod_r[2] <= CPROD_W'(rgb_r[1].b) * CPROD_W'(light_r);
    end
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        ch_r[i] <= ch_nxt[i];
      end
    end
  end

  assign up_rdy            = en[0];
  assign dn_vld            = v_r[NST-1];
  assign dn_data.lit_red   = ch_r[0];
  assign dn_data.lit_green = ch_r[1];
  assign dn_data.lit_blue  = ch_r[2];

endmodule

`default_nettype wire

@@ rtl/flat_face_lambert_shading_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel   handshake                          payload
// in        in_valid / in_stall                in_data  (in_beat_t)
// out       out_valid / out_stall              out_data (out_beat_t)
// cfg       cfg_psel/penable/pwrite/pready     cfg_paddr, cfg_pwdata, cfg_prdata
//
// One triangle per cycle while out_stall is low; pipeline stages: 7 geometry,
// 16 square root, 9 divide (setup, then two quotient bits a stage), 4 shading.
// Reset is synchronous, active low; it clears the stage valids and loads
// the register defaults. Each stage advances when it is empty or the one
// after it moves, so bubbles close up and a stalled output holds its beat.

module flat_face_lambert_shading_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  fflsh_pkg::in_beat_t   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output fflsh_pkg::out_beat_t  out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [4:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);
  import fflsh_pkg::*;

  shade_cfg_t cfg_r;
  logic       cfg_wr;
  logic [2:0] cfg_idx;

  logic                    g_vld, g_rdy;
  logic [SQ_W-1:0]         g_sq;
  logic signed [DOT_W-1:0] g_dot;
  rgb_t                    g_rgb;

  logic                    s_vld, s_rdy;
  logic [ROOT_W-1:0]       s_len;
  logic signed [DOT_W-1:0] s_dot;
  rgb_t                    s_rgb;

  logic                    d_vld, d_rdy;
  logic [DIFF_W-1:0]       d_diff;
  rgb_t                    d_rgb;

  logic                    up_rdy;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sun_x          <= SUN_X_RST;
      cfg_r.sun_y          <= SUN_Y_RST;
      cfg_r.sun_z          <= SUN_Z_RST;
      cfg_r.ambient_weight <= AMBIENT_RST;
      cfg_r.diffuse_weight <= DIFFUSE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SUN_X:   cfg_r.sun_x          <= cfg_pwdata[VERT_W-1:0];
        REG_SUN_Y:   cfg_r.sun_y          <= cfg_pwdata[VERT_W-1:0];
        REG_SUN_Z:   cfg_r.sun_z          <= cfg_pwdata[VERT_W-1:0];
        REG_AMBIENT: cfg_r.ambient_weight <= cfg_pwdata[WGT_W-1:0];
        REG_DIFFUSE: cfg_r.diffuse_weight <= cfg_pwdata[WGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SUN_X:   cfg_prdata = 32'(unsigned'(cfg_r.sun_x));
      REG_SUN_Y:   cfg_prdata = 32'(unsigned'(cfg_r.sun_y));
      REG_SUN_Z:   cfg_prdata = 32'(unsigned'(cfg_r.sun_z));
      REG_AMBIENT: cfg_prdata = 32'(cfg_r.ambient_weight);
      REG_DIFFUSE: cfg_prdata = 32'(cfg_r.diffuse_weight);
      default:     cfg_prdata = '0;
    endcase
  end

  assign in_stall = !up_rdy;

  fflsh_geom u_geom (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .up_vld  (in_valid),
    .up_rdy  (up_rdy),
    .up_data (in_data),
    .dn_vld  (g_vld),
    .dn_rdy  (g_rdy),
    .dn_sq   (g_sq),
    .dn_dot  (g_dot),
    .dn_rgb  (g_rgb)
  );

  fflsh_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .up_vld (g_vld),
    .up_rdy (g_rdy),
    .up_sq  (g_sq),
    .up_dot (g_dot),
    .up_rgb (g_rgb),
    .dn_vld (s_vld),
    .dn_rdy (s_rdy),
    .dn_len (s_len),
    .dn_dot (s_dot),
    .dn_rgb (s_rgb)
  );

  fflsh_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_vld  (s_vld),
    .up_rdy  (s_rdy),
    .up_len  (s_len),
    .up_dot  (s_dot),
    .up_rgb  (s_rgb),
    .dn_vld  (d_vld),
    .dn_rdy  (d_rdy),
    .dn_diff (d_diff),
    .dn_rgb  (d_rgb)
  );

  fflsh_shade u_shade (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .up_vld  (d_vld),
    .up_rdy  (d_rdy),
    .up_diff (d_diff),
    .up_rgb  (d_rgb),
    .dn_vld  (out_valid),
    .dn_rdy  (!out_stall),
    .dn_data (out_data)
  );

endmodule

`default_nettype wire

@@ rtl/fflsh_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fflsh_chk (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input fflsh_pkg::out_beat_t  out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_drained_takes: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output side empty");

  a_flow_takes: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output drains");

endmodule

bind flat_face_lambert_shading_core fflsh_chk u_chk (.*);

`default_nettype wire

@@ test/flat_face_lambert_shading_core_tb.sv @@
`timescale 1ns / 1ps

module flat_face_lambert_shading_core_tb;
  import fflsh_pkg::*;

  localparam int LATENCY = 36;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  flat_face_lambert_shading_core uut (.*);

  always #10 clk = ~clk;

  // shadow copy of the shading registers
  logic signed [15:0] sun_x_q, sun_y_q, sun_z_q;
  logic [14:0] ambient_q, diffuse_q;

  in_beat_t tri_queue[$];
  out_beat_t color_queue[$];
  int mismatches = 0;
  int cycles = 0;
  int gap_left = 0;
  int ostall_left = 0;
  bit hold_send = 1'b0;
  bit stall_on = 1'b1;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic out_beat_t shade_face(in_beat_t t);
    longint e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz, dot, mx;
    longint unsigned sq, len, dif, light;
    int k;
    out_beat_t o;
    e1x = longint'(t.vert1_x) - t.vert0_x;
    e1y = longint'(t.vert1_y) - t.vert0_y;
    e1z = longint'(t.vert1_z) - t.vert0_z;
    e2x = longint'(t.vert2_x) - t.vert0_x;
    e2y = longint'(t.vert2_y) - t.vert0_y;
    e2z = longint'(t.vert2_z) - t.vert0_z;
    nx = e1y * e2z - e1z * e2y;
    ny = e1z * e2x - e1x * e2z;
    nz = e1x * e2y - e1y * e2x;
    mx = nx < 0 ? -nx : nx;
    if ((ny < 0 ? -ny : ny) > mx) mx = ny < 0 ? -ny : ny;
    if ((nz < 0 ? -nz : nz) > mx) mx = nz < 0 ? -nz : nz;
    k = 0;
    while ((mx >> k) >= 64'h4000_0000) k++;
    // magnitude shift, sign kept
    nx = nx < 0 ? -((-nx) >> k) : nx >> k;
    ny = ny < 0 ? -((-ny) >> k) : ny >> k;
    nz = nz < 0 ? -((-nz) >> k) : nz >> k;
    sq = nx * nx + ny * ny + nz * nz;
    len = int_sqrt(sq);
    dot = longint'(sun_x_q) * nx + longint'(sun_y_q) * ny + longint'(sun_z_q) * nz;
    dif = 0;
    if (dot > 0 && len != 0) begin
      dif = longint'(dot) / len;
      if (dif > 65535) dif = 65535;
    end
    light = ambient_q + ((diffuse_q * dif) >> 14);
    o.lit_red = ((t.base_red * light) >> 14) > 255 ? 8'd255 : 8'((t.base_red * light) >> 14);
    o.lit_green = ((t.base_green * light) >> 14) > 255 ? 8'd255 :
                  8'((t.base_green * light) >> 14);
    o.lit_blue = ((t.base_blue * light) >> 14) > 255 ? 8'd255 :
                 8'((t.base_blue * light) >> 14);
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        color_queue = {color_queue, shade_face(in_data)};
        void'(tri_queue.pop_front());
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (!hold_send && tri_queue.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= tri_queue[0];
          gap_left <= stall_on ? pick_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (color_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat %h", out_data);
        end else begin
          if (out_data.lit_red !== color_queue[0].lit_red ||
              out_data.lit_green !== color_queue[0].lit_green ||
              out_data.lit_blue !== color_queue[0].lit_blue) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %h actual %h", color_queue[0], out_data);
          end
          void'(color_queue.pop_front());
        end
      end
      if (ostall_left > 0) begin
        ostall_left <= ostall_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (stall_on) ostall_left <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (tri_queue.size() != 0 || in_valid || color_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_SUN_X: sun_x_q = val[15:0];
      REG_SUN_Y: sun_y_q = val[15:0];
      REG_SUN_Z: sun_z_q = val[15:0];
      REG_AMBIENT: ambient_q = val[14:0];
      REG_DIFFUSE: diffuse_q = val[14:0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [15:0] sx, logic [15:0] sy, logic [15:0] sz,
                         logic [14:0] amb, logic [14:0] dif);
    write_reg(REG_SUN_X, {16'hdead, sx});
    write_reg(REG_SUN_Y, {16'h0000, sy});
    write_reg(REG_SUN_Z, {16'hffff, sz});
    write_reg(REG_AMBIENT, {17'h1ffff, amb});
    write_reg(REG_DIFFUSE, {17'h0, dif});
  endtask

  function automatic in_beat_t make_tri(logic [15:0] a[9], logic [23:0] rgb);
    in_beat_t t;
    {t.base_red, t.base_green, t.base_blue} = rgb;
    {t.vert0_x, t.vert0_y, t.vert0_z} = {a[0], a[1], a[2]};
    {t.vert1_x, t.vert1_y, t.vert1_z} = {a[3], a[4], a[5]};
    {t.vert2_x, t.vert2_y, t.vert2_z} = {a[6], a[7], a[8]};
    return t;
  endfunction

  function automatic in_beat_t random_tri();
    logic [15:0] a[9];
    int mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) begin
      if (mode < 4) a[i] = 16'($urandom_range(0, 2047)) - 16'd1024;
      else if (mode < 5) a[i] = ($urandom_range(0, 1) ? 16'h8000 : 16'h7fff);
      else a[i] = 16'($urandom);
    end
    // degenerate: repeat a vertex
    if (mode == 9) for (int i = 0; i < 3; i++) a[3 + i] = a[i];
    return make_tri(a, 24'($urandom));
  endfunction

  task automatic random_batch(int n);
    for (int i = 0; i < n; i++) tri_queue = {tri_queue, random_tri()};
    wait_drained();
  endtask

  initial begin
    logic [15:0] a[9];
    sun_x_q = SUN_X_RST;
    sun_y_q = SUN_Y_RST;
    sun_z_q = SUN_Z_RST;
    ambient_q = AMBIENT_RST;
    diffuse_q = DIFFUSE_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: facing sun, facing away, degenerate, extremes
    a = '{16'd0, 16'd0, 16'd0, 16'd256, 16'd0, 16'd0, 16'd0, 16'd256, 16'd0};
    tri_queue = {tri_queue, make_tri(a, 24'hffffff)};
    a = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd256, 16'd0, 16'd256, 16'd0, 16'd0};
    tri_queue = {tri_queue, make_tri(a, 24'h80ff01)};
    a = '{16'd5, 16'd5, 16'd5, 16'd5, 16'd5, 16'd5, 16'd9, 16'd2, 16'd7};
    tri_queue = {tri_queue, make_tri(a, 24'hff0000)};
    a = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
          16'h8000, 16'h7fff, 16'h8000};
    tri_queue = {tri_queue, make_tri(a, 24'h00ff00)};
    a = '{16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
          16'h7fff, 16'h8000, 16'h7fff};
    tri_queue = {tri_queue, make_tri(a, 24'h0000ff)};
    a = '{16'hffff, 16'h0001, 16'h0000, 16'h0001, 16'hffff, 16'h0000,
          16'h0000, 16'h0000, 16'h0001};
    tri_queue = {tri_queue, make_tri(a, 24'h5aa5c3)};
    for (int i = 0; i < 10; i++) tri_queue = {tri_queue, random_tri()};
    wait_drained();

    // over-bright weights with the maximal sun, the most negative sun with zero weights, a mixed sun
    set_all(16'h7fff, 16'h7fff, 16'h7fff, 15'h7fff, 15'h7fff);
    random_batch(80);
    set_all(16'h8000, 16'h8000, 16'h8000, 15'd0, 15'd0);
    random_batch(60);
    set_all(16'h8000, 16'h0000, 16'h7fff, 15'd0, 15'h7fff);
    random_batch(60);

    // sender pauses until drained midway through a batch
    set_all(16'($urandom), 16'($urandom), 16'($urandom), 15'($urandom), 15'($urandom));
    for (int i = 0; i < 40; i++) tri_queue = {tri_queue, random_tri()};
    repeat (20) @(posedge clk);
    hold_send = 1'b1;
    while (color_queue.size() != 0 || in_valid) @(posedge clk);
    hold_send = 1'b0;
    wait_drained();

    // back-to-back stretch without idling
    stall_on = 1'b0;
    random_batch(120);
    stall_on = 1'b1;

    for (int p = 0; p < 5; p++) begin
      set_all(16'($urandom), 16'($urandom), 16'($urandom),
              15'($urandom_range(0, 20000)), 15'($urandom_range(0, 20000)));
      random_batch(90);
    end

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
